// ----- rtl/dtq_pkg.sv -----
// Package: shared types, codes and constants of the deadline timer queue.
`default_nettype none
package dtq_pkg;

  localparam int DTQ_CAPACITY = 32;
  localparam int ID_W = 32;
  localparam int TIME_W = 48;
  localparam int DUR_W = 32;
  localparam int DELAY_W = 32;

  typedef enum logic [1:0] {
    REQ_ADD         = 2'd0,
    REQ_CANCEL      = 2'd1,
    REQ_CANCEL_FIRE = 2'd2,
    REQ_TICK        = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    K_ADDED       = 3'd0,
    K_FIRED_NOW   = 3'd1,
    K_CANCEL_DONE = 3'd2,
    K_EXPIRED     = 3'd3,
    K_TICK_DONE   = 3'd4,
    K_FULL        = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SK_FIND,
    SK_MIN,
    SK_PICK
  } scan_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] dl;
  } entry_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] dl;
    logic              found;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/dtq_if.sv -----
// Interfaces: request and result channels of the deadline timer queue.
`default_nettype none
interface dtq_in_if;
  import dtq_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [DUR_W-1:0]  duration;
  logic [ID_W-1:0]   target_id;
  modport source (output valid, req_type, duration, target_id, input ready);
  modport sink (input valid, req_type, duration, target_id, output ready);
endinterface

interface dtq_out_if;
  import dtq_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         result_kind;
  logic [ID_W-1:0]    timer_id;
  logic [TIME_W-1:0]  deadline;
  logic               found;
  logic [DELAY_W-1:0] next_delay;
  logic               last;
  modport source (output valid, result_kind, timer_id, deadline, found, next_delay, last,
                  input ready);
  modport sink (input valid, result_kind, timer_id, deadline, found, next_delay, last,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/dtq_mem.sv -----
// Entry memory: one write port, one registered read port.
`default_nettype none
module dtq_mem
  import dtq_pkg::*;
#(
  parameter int CAPACITY = DTQ_CAPACITY
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [$clog2(CAPACITY)-1:0] waddr,
  input  wire entry_t                      wdata,
  input  wire logic [$clog2(CAPACITY)-1:0] raddr,
  output entry_t                           rdata
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/deadline_timer_queue.sv -----
// Top level: deadline-ordered one-shot timer table with its own millisecond clock.
//
// The block holds up to CAPACITY timers in one entry memory (id and deadline) with a
// valid flop per slot, and takes one request at a time. Every request ends with a full
// pass over the entry memory, one entry per cycle through its single read port, to find
// the earliest remaining deadline, so every result of a request carries the delay valid
// after that request. A cancel first makes a pass to find its target, and a tick selects
// each timer that it expires in turn: each expiry is found by a selection pass over the
// due entries, in deadline order and then id order, with slot order breaking full ties.
// Results wait in an output register; a stalled output stalls the block. Deadlines and
// the clock saturate at 2^48-1.
`default_nettype none
module deadline_timer_queue
  import dtq_pkg::*;
#(
  parameter int CAPACITY = DTQ_CAPACITY
) (
  input wire logic  clk,
  input wire logic  rst_n,
  dtq_in_if.sink    in_ch,
  dtq_out_if.source out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t               state_r, state_nxt;
  scan_t                scan_r, scan_nxt;
  req_t                 req_r, req_nxt;
  logic [ID_W-1:0]      tgt_r, tgt_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pend_idx_r, pend_idx_nxt;
  logic                 hit_r, hit_nxt;
  logic [AW-1:0]        hit_slot_r, hit_slot_nxt;
  logic [TIME_W-1:0]    hit_dl_r, hit_dl_nxt;
  logic                 any_r, any_nxt;
  logic [TIME_W-1:0]    best_r, best_nxt;
  logic [ID_W-1:0]      best_id_r, best_id_nxt;
  logic [AW-1:0]        best_slot_r, best_slot_nxt;
  logic [CAPACITY-1:0]  due_r, due_nxt;
  logic [CAPACITY-1:0]  valid_r, valid_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [ID_W-1:0]      next_id_r, next_id_nxt;
  logic [DELAY_W-1:0]   delay_r, delay_nxt;
  res_t                 res0_r, res0_nxt;
  res_t                 res1_r, res1_nxt;
  logic                 two_r, two_nxt;
  logic                 emit_i_r, emit_i_nxt;
  logic                 final_r, final_nxt;
  logic                 tick_r, tick_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r, out_res_nxt;
  logic [DELAY_W-1:0]   out_delay_r, out_delay_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 accept, out_free, full;
  logic [AW-1:0]        free_slot;
  logic                 mem_we;
  entry_t               mem_wdata, mem_q;
  logic [AW-1:0]        mem_raddr;
  logic [TIME_W:0]      add_sum;
  logic [TIME_W-1:0]    add_dl, diff;
  logic [DELAY_W-1:0]   delay_calc;
  logic                 scan_done;

  dtq_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (free_slot),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_slot = AW'(i);
      end
    end
  end

  assign full      = &valid_r;
  assign accept    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign add_sum   = {1'b0, now_r} + {{(TIME_W + 1 - DUR_W){1'b0}}, in_ch.duration};
  assign add_dl    = add_sum[TIME_W] ? {TIME_W{1'b1}} : add_sum[TIME_W-1:0];
  assign diff      = best_r - now_r;
  assign mem_raddr = cnt_r[AW-1:0];
  assign scan_done = (cnt_r == CW'(CAPACITY)) && !pend_r;
  assign mem_wdata = '{id: next_id_r, dl: add_dl};

  // Delay to the earliest deadline; 1 when none is later than now.
  always_comb begin
    if (!any_r || best_r <= now_r) begin
      delay_calc = DELAY_W'(1);
    end else if (diff[TIME_W-1:DELAY_W] != '0) begin
      delay_calc = {DELAY_W{1'b1}};
    end else begin
      delay_calc = diff[DELAY_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    req_nxt       = req_r;
    tgt_nxt       = tgt_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    hit_dl_nxt    = hit_dl_r;
    any_nxt       = any_r;
    best_nxt      = best_r;
    best_id_nxt   = best_id_r;
    best_slot_nxt = best_slot_r;
    due_nxt       = due_r;
    valid_nxt     = valid_r;
    now_nxt       = now_r;
    next_id_nxt   = next_id_r;
    delay_nxt     = delay_r;
    res0_nxt      = res0_r;
    res1_nxt      = res1_r;
    two_nxt       = two_r;
    emit_i_nxt    = emit_i_r;
    final_nxt     = final_r;
    tick_nxt      = tick_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_res_nxt   = out_res_r;
    out_delay_nxt = out_delay_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt    = req_t'(in_ch.req_type);
          tgt_nxt    = in_ch.target_id;
          tick_nxt   = 1'b0;
          final_nxt  = 1'b1;
          two_nxt    = 1'b0;
          emit_i_nxt = 1'b0;
          cnt_nxt    = '0;
          pend_nxt   = 1'b0;
          any_nxt    = 1'b0;
          hit_nxt    = 1'b0;
          state_nxt  = S_SCAN;
          scan_nxt   = SK_MIN;
          case (req_t'(in_ch.req_type))
            REQ_ADD: begin
              if (in_ch.duration == '0) begin
                res0_nxt    = '{kind: K_FIRED_NOW, id: next_id_r, dl: now_r, found: 1'b0};
                next_id_nxt = next_id_r + ID_W'(1);
              end else if (full) begin
                res0_nxt = '{kind: K_FULL, id: '0, dl: '0, found: 1'b0};
              end else begin
                mem_we               = 1'b1;
                valid_nxt[free_slot] = 1'b1;
                res0_nxt    = '{kind: K_ADDED, id: next_id_r, dl: add_dl, found: 1'b0};
                next_id_nxt = next_id_r + ID_W'(1);
              end
            end
            REQ_CANCEL, REQ_CANCEL_FIRE: begin
              scan_nxt = SK_FIND;
            end
            REQ_TICK: begin
              now_nxt  = (now_r == {TIME_W{1'b1}}) ? now_r : now_r + TIME_W'(1);
              tick_nxt = 1'b1;
            end
            default: begin
              scan_nxt = SK_MIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read a cycle; evaluate the entry read the cycle before.
        if (cnt_r != CW'(CAPACITY)) begin
          cnt_nxt      = cnt_r + CW'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[AW-1:0];
        end else begin
          pend_nxt = 1'b0;
        end

        if (pend_r) begin
          case (scan_r)
            SK_FIND: begin
              if (valid_r[pend_idx_r] && mem_q.id == tgt_r && !hit_r) begin
                hit_nxt      = 1'b1;
                hit_slot_nxt = pend_idx_r;
                hit_dl_nxt   = mem_q.dl;
              end
            end
            SK_MIN: begin
              if (tick_r) begin
                due_nxt[pend_idx_r] = valid_r[pend_idx_r] && mem_q.dl <= now_r;
              end
              if (valid_r[pend_idx_r] && (!tick_r || mem_q.dl > now_r) &&
                  (!any_r || mem_q.dl < best_r)) begin
                any_nxt  = 1'b1;
                best_nxt = mem_q.dl;
              end
            end
            SK_PICK: begin
              if (due_r[pend_idx_r] && (!any_r || mem_q.dl < best_r ||
                  (mem_q.dl == best_r && mem_q.id < best_id_r))) begin
                any_nxt       = 1'b1;
                best_nxt      = mem_q.dl;
                best_id_nxt   = mem_q.id;
                best_slot_nxt = pend_idx_r;
              end
            end
            default: begin
              any_nxt = any_r;
            end
          endcase
        end

        if (scan_done) begin
          cnt_nxt = '0;
          any_nxt = 1'b0;
          hit_nxt = 1'b0;
          case (scan_r)
            SK_FIND: begin
              scan_nxt = SK_MIN;
              if (hit_r) begin
                valid_nxt[hit_slot_r] = 1'b0;
                if (req_r == REQ_CANCEL_FIRE) begin
                  res0_nxt = '{kind: K_EXPIRED, id: tgt_r, dl: hit_dl_r, found: 1'b1};
                  res1_nxt = '{kind: K_CANCEL_DONE, id: tgt_r, dl: hit_dl_r, found: 1'b1};
                  two_nxt  = 1'b1;
                end else begin
                  res0_nxt = '{kind: K_CANCEL_DONE, id: tgt_r, dl: hit_dl_r, found: 1'b1};
                end
              end else begin
                res0_nxt = '{kind: K_CANCEL_DONE, id: tgt_r, dl: '0, found: 1'b0};
              end
            end
            SK_MIN: begin
              delay_nxt = delay_calc;
              if (tick_r) begin
                scan_nxt = SK_PICK;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            SK_PICK: begin
              state_nxt  = S_EMIT;
              emit_i_nxt = 1'b0;
              two_nxt    = 1'b0;
              if (any_r) begin
                res0_nxt = '{kind: K_EXPIRED, id: best_id_r, dl: best_r, found: 1'b0};
                final_nxt = 1'b0;
                valid_nxt[best_slot_r] = 1'b0;
                due_nxt[best_slot_r]   = 1'b0;
              end else begin
                res0_nxt  = '{kind: K_TICK_DONE, id: '0, dl: '0, found: 1'b0};
                final_nxt = 1'b1;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = emit_i_r ? res1_r : res0_r;
          out_delay_nxt = delay_r;
          out_last_nxt  = final_r && (emit_i_r == two_r);
          if (emit_i_r == two_r) begin
            if (final_r) begin
              state_nxt = S_IDLE;
            end else begin
              // Next expiry: another selection pass over the due entries.
              state_nxt = S_SCAN;
              scan_nxt  = SK_PICK;
              cnt_nxt   = '0;
              pend_nxt  = 1'b0;
              any_nxt   = 1'b0;
            end
          end else begin
            emit_i_nxt = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= SK_MIN;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      due_r       <= '0;
      now_r       <= '0;
      next_id_r   <= ID_W'(1);
      out_valid_r <= 1'b0;
      emit_i_r    <= 1'b0;
      two_r       <= 1'b0;
      final_r     <= 1'b1;
      tick_r      <= 1'b0;
      hit_r       <= 1'b0;
      any_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      due_r       <= due_nxt;
      now_r       <= now_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      emit_i_r    <= emit_i_nxt;
      two_r       <= two_nxt;
      final_r     <= final_nxt;
      tick_r      <= tick_nxt;
      hit_r       <= hit_nxt;
      any_r       <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    tgt_r       <= tgt_nxt;
    pend_idx_r  <= pend_idx_nxt;
    hit_slot_r  <= hit_slot_nxt;
    hit_dl_r    <= hit_dl_nxt;
    best_r      <= best_nxt;
    best_id_r   <= best_id_nxt;
    best_slot_r <= best_slot_nxt;
    delay_r     <= delay_nxt;
    res0_r      <= res0_nxt;
    res1_r      <= res1_nxt;
    out_res_r   <= out_res_nxt;
    out_delay_r <= out_delay_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Ports: take requests only between items; drive results from the output register.
  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_res_r.kind;
  assign out_ch.timer_id    = out_res_r.id;
  assign out_ch.deadline    = out_res_r.dl;
  assign out_ch.found       = out_res_r.found;
  assign out_ch.next_delay  = out_delay_r;
  assign out_ch.last        = out_last_r;

  // The clock only moves on an accepted tick.
  a_now_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(now_r))
    else $error("clock changed while busy");

  // Only entries still in the table may be picked for expiry.
  a_due_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_r == SK_PICK) |-> ((due_r & ~valid_r) == '0))
    else $error("due entry not valid");

  // Emission index never passes the result count.
  a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (!emit_i_r || two_r))
    else $error("emit index out of range");

  // The scan counter stays within the table.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CW'(CAPACITY)))
    else $error("scan counter out of range");

endmodule
`default_nettype wire

// ----- dv/tb_deadline_timer_queue.sv -----
// Testbench: directed and random checks of the deadline timer queue against a local predictor.
`timescale 1ns / 1ps
module tb_deadline_timer_queue
  import dtq_pkg::*;
();

  localparam int CAP = DTQ_CAPACITY;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id;
    logic [47:0] dl;
    logic        found;
    logic [31:0] delay;
    logic        last;
  } timer_res_t;

  typedef struct {
    req_t        req;
    logic [31:0] dur;
    logic [31:0] tgt;
    bit          typed;   // expected first result given in the row
    timer_res_t  first;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dtq_in_if  in_ch ();
  dtq_out_if out_ch ();

  deadline_timer_queue uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private copy of the timer table and clock.
  bit          tbl_valid [CAP];
  logic [31:0] tbl_id [CAP];
  logic [47:0] tbl_dl [CAP];
  logic [47:0] clock_ms;
  logic [31:0] id_counter;

  timer_res_t expected_q[$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [31:0] recent_ids[$];

  function automatic logic [31:0] earliest_delay();
    bit          any;
    logic [47:0] best;
    logic [47:0] diff;
    any = 0;
    best = '0;
    for (int i = 0; i < CAP; i++)
      if (tbl_valid[i] && (!any || tbl_dl[i] < best)) begin
        best = tbl_dl[i];
        any = 1;
      end
    if (!any || best <= clock_ms) return 32'd1;
    diff = best - clock_ms;
    return (diff > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
  endfunction

  function automatic timer_res_t mk(logic [2:0] k, logic [31:0] id, logic [47:0] dl,
                                    logic f);
    timer_res_t r;
    r = '0;
    r.kind = k;
    r.id = id;
    r.dl = dl;
    r.found = f;
    return r;
  endfunction

  // Work out the results of one accepted request and queue them.
  task automatic predict_timer_request(req_t req, logic [31:0] dur, logic [31:0] tgt);
    timer_res_t  res[$];
    int          slot;
    int          pick;
    bit          due [CAP];
    logic [48:0] sum;
    logic [31:0] d;
    slot = -1;
    case (req)
      REQ_ADD: begin
        if (dur == 0) begin
          res = {res, mk(K_FIRED_NOW, id_counter, clock_ms, 1'b0)};
          id_counter++;
        end else begin
          for (int i = CAP - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
          if (slot < 0) begin
            res = {res, mk(K_FULL, '0, '0, 1'b0)};
          end else begin
            sum = {1'b0, clock_ms} + {17'b0, dur};
            tbl_valid[slot] = 1;
            tbl_id[slot] = id_counter;
            tbl_dl[slot] = sum[48] ? TIME_MAX : sum[47:0];
            res = {res, mk(K_ADDED, id_counter, tbl_dl[slot], 1'b0)};
            recent_ids = {recent_ids, id_counter};
            if (recent_ids.size() > 40) void'(recent_ids.pop_front());
            id_counter++;
          end
        end
      end
      REQ_CANCEL, REQ_CANCEL_FIRE: begin
        for (int i = CAP - 1; i >= 0; i--) if (tbl_valid[i] && tbl_id[i] == tgt) slot = i;
        if (slot < 0) begin
          res = {res, mk(K_CANCEL_DONE, tgt, '0, 1'b0)};
        end else begin
          tbl_valid[slot] = 0;
          if (req == REQ_CANCEL_FIRE) res = {res, mk(K_EXPIRED, tgt, tbl_dl[slot], 1'b1)};
          res = {res, mk(K_CANCEL_DONE, tgt, tbl_dl[slot], 1'b1)};
        end
      end
      default: begin
        if (clock_ms != TIME_MAX) clock_ms++;
        for (int i = 0; i < CAP; i++) due[i] = tbl_valid[i] && tbl_dl[i] <= clock_ms;
        forever begin
          pick = -1;
          for (int i = 0; i < CAP; i++)
            if (due[i] && (pick < 0 || tbl_dl[i] < tbl_dl[pick] ||
                (tbl_dl[i] == tbl_dl[pick] && tbl_id[i] < tbl_id[pick])))
              pick = i;
          if (pick < 0) break;
          due[pick] = 0;
          tbl_valid[pick] = 0;
          res = {res, mk(K_EXPIRED, tbl_id[pick], tbl_dl[pick], 1'b0)};
        end
        res = {res, mk(K_TICK_DONE, '0, '0, 1'b0)};
      end
    endcase
    d = earliest_delay();
    foreach (res[i]) begin
      res[i].delay = d;
      res[i].last = (i == res.size() - 1);
      expected_q = {expected_q, res[i]};
    end
  endtask

  // Drive one request and hold it until the transfer; predict at acceptance.
  task automatic send_request(req_t req, logic [31:0] dur, logic [31:0] tgt);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.duration <= dur;
    in_ch.target_id <= tgt;
    do @(posedge clk); while (!in_ch.ready);
    predict_timer_request(req, dur, tgt);
  endtask

  // Receiver: random backpressure, compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    timer_res_t got;
    timer_res_t want;
    if (rst_n) begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.result_kind, out_ch.timer_id, out_ch.deadline, out_ch.found,
                out_ch.next_delay, out_ch.last};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  // Hand-typed first results are checked as they are predicted.
  task automatic check_typed(timer_res_t want);
    timer_res_t got;
    got = expected_q[expected_q.size() - 1];
    // compare against the first result of this row: walk back to its head
    for (int i = expected_q.size() - 1; i >= 0; i--) begin
      if (i == 0 || expected_q[i - 1].last) begin
        got = expected_q[i];
        break;
      end
    end
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("typed row: expected %p predicted %p", want, got);
    end
  endtask

  // Drop valid and wait until every expected result has come.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  stim_row_t rows[$];

  function automatic stim_row_t row(req_t r, logic [31:0] du, logic [31:0] tg, bit t,
                                    timer_res_t f);
    stim_row_t s;
    s.req = r;
    s.dur = du;
    s.tgt = tg;
    s.typed = t;
    s.first = f;
    return s;
  endfunction

  initial begin
    #50_000_000;
    $display("tb_deadline_timer_queue: errors");
    $finish;
  end

  initial begin
    req_t        r;
    logic [31:0] du;
    logic [31:0] tg;
    int          sel;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.duration = '0;
    in_ch.target_id = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < CAP; i++) tbl_valid[i] = 0;
    clock_ms = '0;
    id_counter = 32'd1;

    // Directed: fire at reset, extremes, cancels, duplicate-deadline tick.
    rows = {rows, row(REQ_ADD, 0, 0, 1, '{K_FIRED_NOW, 32'd1, 48'd0, 1'b0, 32'd1, 1'b1})};
    rows = {rows, row(REQ_TICK, 0, 0, 1, '{K_TICK_DONE, 32'd0, 48'd0, 1'b0, 32'd1, 1'b1})};
    rows = {rows, row(REQ_ADD, 32'hFFFF_FFFF, 0, 1,
                      '{K_ADDED, 32'd2, 48'h1_0000_0000, 1'b0, 32'hFFFF_FFFF, 1'b1})};
    rows = {rows, row(REQ_CANCEL, 0, 32'hFFFF_FFFF, 1,
                      '{K_CANCEL_DONE, 32'hFFFF_FFFF, 48'd0, 1'b0, 32'hFFFF_FFFF, 1'b1})};
    rows = {rows, row(REQ_ADD, 2, 0, 0, '0)};
    rows = {rows, row(REQ_ADD, 2, 0, 0, '0)};
    rows = {rows, row(REQ_ADD, 1, 0, 0, '0)};
    rows = {rows, row(REQ_CANCEL_FIRE, 0, 32'd5, 0, '0)};
    rows = {rows, row(REQ_CANCEL_FIRE, 0, 32'd5, 0, '0)};
    rows = {rows, row(REQ_TICK, 0, 0, 0, '0)};
    rows = {rows, row(REQ_TICK, 0, 0, 0, '0)};
    rows = {rows, row(REQ_CANCEL, 0, 32'd2, 0, '0)};
    rows = {rows, row(REQ_CANCEL, 0, 32'd0, 0, '0)};
    rows = {rows, row(REQ_TICK, 0, 0, 0, '0)};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_request(rows[i].req, rows[i].dur, rows[i].tgt);
      if (rows[i].typed) check_typed(rows[i].first);
    end
    drain();

    // Fill the table, hit full, fire at once while full, then expire all over two ticks.
    for (int i = 0; i < CAP + 1; i++) send_request(REQ_ADD, 32'd1 + (i % 3 == 0), 0);
    send_request(REQ_ADD, 0, 0);
    send_request(REQ_TICK, 0, 0);
    send_request(REQ_TICK, 0, 0);
    // Pause until the table has answered everything.
    drain();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 49 : (ph == 3) ? 12 : 0;
      recv_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 12 : 0;
      for (int n = 0; n < 70; n++) begin
        sel = $urandom_range(99);
        du = '0;
        tg = '0;
        if (sel < 40) begin
          r = REQ_ADD;
          case ($urandom_range(7))
            0: du = 0;
            1: du = $urandom;
            default: du = $urandom_range(1, 8);
          endcase
        end else if (sel < 60) begin
          r = ($urandom_range(1)) ? REQ_CANCEL : REQ_CANCEL_FIRE;
          if (recent_ids.size() != 0 && $urandom_range(3) != 0)
            tg = recent_ids[$urandom_range(recent_ids.size() - 1)];
          else
            tg = $urandom;
        end else begin
          r = REQ_TICK;
        end
        send_request(r, du, tg);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    drain();
    if (mismatches == 0 && expected_q.size() == 0)
      $display("tb_deadline_timer_queue: clean");
    else
      $display("tb_deadline_timer_queue: errors");
    $finish;
  end

endmodule
